// File: rtl/ptts_pkg.sv
package ptts_pkg;

  localparam int INDEX_BITS = 20;
  localparam int COORD_BITS = 24;
  localparam int HELD_DEPTH = 4;
  localparam int HELD_BITS = 2;
  localparam int POS_BITS = 3;
  localparam int COUNT_SAT = 5;
  localparam int SQ_BITS = 2 * COORD_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;
  localparam int BURST_MAX = 3;
  localparam int BURST_BITS = 2;

  typedef struct packed {
    logic [INDEX_BITS-1:0] a;
    logic [INDEX_BITS-1:0] b;
    logic [INDEX_BITS-1:0] c;
    logic                  last;
  } tri_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic [POS_BITS-1:0]   pos;
    logic                  face_end;
  } corner_t;

  typedef struct packed {
    logic [SQ_BITS-1:0] sx;
    logic [SQ_BITS-1:0] sy;
    logic [SQ_BITS-1:0] sz;
  } sq_t;

  typedef struct packed {
    logic [BURST_BITS-1:0]  cnt;
    tri_t [BURST_MAX-1:0]   tris;
  } burst_t;

endpackage

// File: rtl/polygon_to_triangle_splitter.sv
// Splits polygon faces into triangles of vertex indices.
// The input takes one corner word per cycle while not stalled: vertex index,
// signed position with 16 fraction bits, face-end flag on the last corner.
// The output gives one triangle word per cycle while not stalled, with
// face_last set on the final triangle of a face. Faces of one or two corners
// give no output. Quads are cut along the shorter diagonal; larger faces
// become a fan. A corner passes an input register, a squaring stage and a
// summing stage before its first triangle shows on the output.
// Throughput is one corner per cycle while the input is not stalled. A corner
// that gives more than one triangle holds the burst register until the last
// one leaves, so the fifth corner of a long face and the end of a quad can
// back up the input. When the receiver stalls, the current triangle holds
// and the pipeline fills; stall reaches the input once all three stages are
// occupied. Reset empties the pipeline and starts a new face; stored corners
// are not cleared and are always rewritten before use.
module polygon_to_triangle_splitter import ptts_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [INDEX_BITS-1:0]        in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic                         in_face_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [INDEX_BITS-1:0]        out_corner_a,
  output logic [INDEX_BITS-1:0]        out_corner_b,
  output logic [INDEX_BITS-1:0]        out_corner_c,
  output logic                         out_face_last
);

  logic    b_take;
  logic    b_valid;
  corner_t b_corner;
  sq_t     b_sq;
  logic    burst_ready;
  logic    burst_load;
  burst_t  burst_word;

  ptts_geom u_geom (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_face_end     (in_face_end),
    .b_take          (b_take),
    .b_valid         (b_valid),
    .b_corner        (b_corner),
    .b_sq            (b_sq)
  );

  ptts_fan u_fan (
    .clk         (clk),
    .rst_n       (rst_n),
    .b_valid     (b_valid),
    .b_corner    (b_corner),
    .b_sq        (b_sq),
    .burst_ready (burst_ready),
    .b_take      (b_take),
    .burst_load  (burst_load),
    .burst_word  (burst_word)
  );

  ptts_burst u_burst (
    .clk           (clk),
    .rst_n         (rst_n),
    .burst_load    (burst_load),
    .burst_word    (burst_word),
    .burst_ready   (burst_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_corner_a  (out_corner_a),
    .out_corner_b  (out_corner_b),
    .out_corner_c  (out_corner_c),
    .out_face_last (out_face_last)
  );

endmodule

// File: rtl/ptts_geom.sv
module ptts_geom import ptts_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [INDEX_BITS-1:0]        in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic                         in_face_end,
  input  logic                         b_take,
  output logic                         b_valid,
  output corner_t                      b_corner,
  output sq_t                          b_sq
);

  logic                         a_valid_r, a_valid_nxt;
  logic [INDEX_BITS-1:0]        a_idx_r;
  logic signed [COORD_BITS-1:0] a_x_r, a_y_r, a_z_r;
  logic                         a_end_r;
  logic [POS_BITS-1:0]          count_r, count_nxt;
  logic signed [COORD_BITS-1:0] h0_x_r, h0_y_r, h0_z_r;
  logic signed [COORD_BITS-1:0] h1_x_r, h1_y_r, h1_z_r;
  logic signed [COORD_BITS-1:0] ref_x, ref_y, ref_z;
  logic [COORD_BITS-1:0]        dx, dy, dz;
  logic [SQ_BITS-1:0]           sx, sy, sz;
  logic                         b_valid_r, b_valid_nxt;
  corner_t                      b_corner_r;
  sq_t                          b_sq_r;
  logic                         a_go;
  logic                         in_fire;

  function automatic logic [COORD_BITS-1:0] mag_diff(logic signed [COORD_BITS-1:0] p,
                                                     logic signed [COORD_BITS-1:0] q);
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] nd;
    d = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    nd = -d;
    return d[COORD_BITS] ? nd[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  assign a_go = a_valid_r && (!b_valid_r || b_take);
  assign in_stall = a_valid_r && !a_go;
  assign in_fire = in_valid && !in_stall;

  assign a_valid_nxt = in_fire ? 1'b1 : (a_go ? 1'b0 : a_valid_r);
  assign b_valid_nxt = a_go ? 1'b1 : (b_take ? 1'b0 : b_valid_r);

  always_comb begin
    count_nxt = count_r;
    if (a_go) begin
      if (a_end_r) begin
        count_nxt = '0;
      end else if (count_r < POS_BITS'(COUNT_SAT)) begin
        count_nxt = count_r + POS_BITS'(1);
      end
    end
  end

  // The third corner measures against the first, the fourth against the second.
  always_comb begin
    if (count_r == POS_BITS'(2)) begin
      ref_x = h0_x_r;
      ref_y = h0_y_r;
      ref_z = h0_z_r;
    end else begin
      ref_x = h1_x_r;
      ref_y = h1_y_r;
      ref_z = h1_z_r;
    end
  end

  assign dx = mag_diff(a_x_r, ref_x);
  assign dy = mag_diff(a_y_r, ref_y);
  assign dz = mag_diff(a_z_r, ref_z);
  assign sx = dx * dx;
  assign sy = dy * dy;
  assign sz = dz * dz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      count_r   <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_idx_r <= in_vertex_index;
      a_x_r   <= in_pos_x;
      a_y_r   <= in_pos_y;
      a_z_r   <= in_pos_z;
      a_end_r <= in_face_end;
    end
    if (a_go) begin
      if (count_r == POS_BITS'(0)) begin
        h0_x_r <= a_x_r;
        h0_y_r <= a_y_r;
        h0_z_r <= a_z_r;
      end
      if (count_r == POS_BITS'(1)) begin
        h1_x_r <= a_x_r;
        h1_y_r <= a_y_r;
        h1_z_r <= a_z_r;
      end
      b_corner_r.idx      <= a_idx_r;
      b_corner_r.pos      <= count_r;
      b_corner_r.face_end <= a_end_r;
      b_sq_r.sx           <= sx;
      b_sq_r.sy           <= sy;
      b_sq_r.sz           <= sz;
    end
  end

  assign b_valid = b_valid_r;
  assign b_corner = b_corner_r;
  assign b_sq = b_sq_r;

endmodule

// File: rtl/ptts_fan.sv
module ptts_fan import ptts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    b_valid,
  input  corner_t b_corner,
  input  sq_t     b_sq,
  input  logic    burst_ready,
  output logic    b_take,
  output logic    burst_load,
  output burst_t  burst_word
);

  logic [INDEX_BITS-1:0] held_r [HELD_DEPTH];
  logic [INDEX_BITS-1:0] prev_r;
  logic [SUM_BITS-1:0]   d02_r;
  logic [SUM_BITS-1:0]   sum;
  logic                  short02;
  logic [INDEX_BITS-1:0] h0, h1, h2, h3, idx;
  logic                  fend;

  assign sum = {2'b00, b_sq.sx} + {2'b00, b_sq.sy} + {2'b00, b_sq.sz};
  assign short02 = d02_r < sum;

  assign h0 = held_r[0];
  assign h1 = held_r[1];
  assign h2 = held_r[2];
  assign h3 = held_r[3];
  assign idx = b_corner.idx;
  assign fend = b_corner.face_end;

  always_comb begin
    burst_word = '0;
    if (b_corner.pos >= POS_BITS'(COUNT_SAT)) begin
      burst_word.cnt = BURST_BITS'(1);
      burst_word.tris[0] = '{a: h0, b: prev_r, c: idx, last: fend};
    end else if (b_corner.pos == POS_BITS'(4)) begin
      burst_word.cnt = BURST_BITS'(3);
      burst_word.tris[0] = '{a: h0, b: h1, c: h2, last: 1'b0};
      burst_word.tris[1] = '{a: h0, b: h2, c: h3, last: 1'b0};
      burst_word.tris[2] = '{a: h0, b: h3, c: idx, last: fend};
    end else if (fend && b_corner.pos == POS_BITS'(2)) begin
      burst_word.cnt = BURST_BITS'(1);
      burst_word.tris[0] = '{a: h0, b: h1, c: idx, last: 1'b1};
    end else if (fend && b_corner.pos == POS_BITS'(3)) begin
      burst_word.cnt = BURST_BITS'(2);
      if (short02) begin
        burst_word.tris[0] = '{a: h0, b: h1, c: h2, last: 1'b0};
        burst_word.tris[1] = '{a: h0, b: h2, c: idx, last: 1'b1};
      end else begin
        burst_word.tris[0] = '{a: h1, b: h2, c: idx, last: 1'b0};
        burst_word.tris[1] = '{a: h1, b: idx, c: h0, last: 1'b1};
      end
    end
  end

  assign b_take = b_valid && (burst_word.cnt == '0 || burst_ready);
  assign burst_load = b_valid && burst_word.cnt != '0 && burst_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (b_take) begin
      prev_r <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      if (b_corner.pos < POS_BITS'(HELD_DEPTH)) begin
        held_r[b_corner.pos[HELD_BITS-1:0]] <= idx;
      end
      if (b_corner.pos == POS_BITS'(2)) begin
        d02_r <= sum;
      end
    end
  end

endmodule

// File: rtl/ptts_burst.sv
module ptts_burst import ptts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  burst_load,
  input  burst_t                burst_word,
  output logic                  burst_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_BITS-1:0] out_corner_a,
  output logic [INDEX_BITS-1:0] out_corner_b,
  output logic [INDEX_BITS-1:0] out_corner_c,
  output logic                  out_face_last
);

  tri_t                  tris_r [BURST_MAX];
  logic                  valid_r, valid_nxt;
  logic [BURST_BITS-1:0] cnt_r;
  logic [BURST_BITS-1:0] k_r, k_nxt;
  logic                  out_fire;
  logic                  done;
  tri_t                  head;

  assign out_fire = valid_r && !out_stall;
  assign done = out_fire && (k_r == cnt_r - BURST_BITS'(1));
  assign burst_ready = !valid_r || done;

  always_comb begin
    valid_nxt = valid_r;
    k_nxt = k_r;
    if (burst_load) begin
      valid_nxt = 1'b1;
      k_nxt = '0;
    end else if (done) begin
      valid_nxt = 1'b0;
    end else if (out_fire) begin
      k_nxt = k_r + BURST_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      k_r     <= k_nxt;
      if (burst_load) begin
        cnt_r <= burst_word.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      for (int i = 0; i < BURST_MAX; i++) begin
        tris_r[i] <= burst_word.tris[i];
      end
    end
  end

  assign head = tris_r[k_r];
  assign out_valid = valid_r;
  assign out_corner_a = head.a;
  assign out_corner_b = head.b;
  assign out_corner_c = head.c;
  assign out_face_last = head.last;

endmodule

// File: rtl/ptts_checker.sv
module ptts_checker import ptts_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [INDEX_BITS-1:0] out_corner_a,
  input logic [INDEX_BITS-1:0] out_corner_b,
  input logic [INDEX_BITS-1:0] out_corner_c,
  input logic                  out_face_last
);

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  // The input can only back up while a triangle word is waiting on the output.
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with nothing on the output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_corner_a) && $stable(out_corner_b) &&
                                  $stable(out_corner_c) && $stable(out_face_last)))
    else $error("output word changed while stalled");

endmodule

bind polygon_to_triangle_splitter ptts_checker u_ptts_checker (.*);
